@@ hdl/tbcb_pkg.sv @@
// ----------------------------------------------------------------------------
// Bayer color bar test pattern: shared definitions
// Register indexes, bar and channel codes, default sizes and the bar lookup.
// ----------------------------------------------------------------------------
package tbcb_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned PIXEL_BITS_DEF = 12;
  localparam int unsigned DIM_BITS_DEF   = 13;

  // Configuration port index width and register indexes.
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_BAYER_PATTERN  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_ENABLE = CFG_IDX_BITS'(3);

  // Register reset values.
  localparam int unsigned FRAME_WIDTH_RST  = 1920;
  localparam int unsigned FRAME_HEIGHT_RST = 1080;

  // Bar block counter and the mask that forms the block width.
  localparam int unsigned BLK_CNT_BITS = 10;
  localparam logic [BLK_CNT_BITS-1:0] BLOCK_MASK = 10'h3FE;

  // Bar codes, left to right.
  localparam logic [2:0] BAR_WHITE   = 3'd0;
  localparam logic [2:0] BAR_BLACK   = 3'd1;
  localparam logic [2:0] BAR_RED     = 3'd2;
  localparam logic [2:0] BAR_GREEN   = 3'd3;
  localparam logic [2:0] BAR_BLUE    = 3'd4;
  localparam logic [2:0] BAR_CYAN    = 3'd5;
  localparam logic [2:0] BAR_MAGENTA = 3'd6;
  localparam logic [2:0] BAR_YELLOW  = 3'd7;

  // Bayer channel codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GR    = 2'd1;
  localparam logic [1:0] CH_GB    = 2'd2;
  localparam logic [1:0] CH_BLUE  = 2'd3;

  // Mode registers that travel together.
  typedef struct packed {
    logic [1:0] bayer_pattern;
    logic       pattern_enable;
  } mode_t;

  // Per-word control carried from the input stage to the output stage.
  typedef struct packed {
    logic       enable;
    logic [1:0] channel;
    logic [2:0] bar;
  } stage_ctl_t;

  // True if the given bar lights the given Bayer channel.
  function automatic logic bar_lit(input logic [2:0] bar, input logic [1:0] ch);
    logic lit;
    case (bar)
      BAR_WHITE:   lit = 1'b1;
      BAR_BLACK:   lit = 1'b0;
      BAR_RED:     lit = (ch == CH_RED);
      BAR_GREEN:   lit = (ch == CH_GR) || (ch == CH_GB);
      BAR_BLUE:    lit = (ch == CH_BLUE);
      BAR_CYAN:    lit = (ch != CH_RED);
      BAR_MAGENTA: lit = (ch == CH_RED) || (ch == CH_BLUE);
      BAR_YELLOW:  lit = (ch != CH_BLUE);
      default:     lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

@@ hdl/tbcb_cfg.sv @@
// ----------------------------------------------------------------------------
// Bayer color bar test pattern: configuration registers
// Holds frame size and mode registers, written through the config channel.
// ----------------------------------------------------------------------------
module tbcb_cfg #(
  parameter int unsigned DIM_BITS = tbcb_pkg::DIM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbcb_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [DIM_BITS-1:0]               cfg_data_i,
  output logic [DIM_BITS-1:0]               frame_width_o,
  output logic [DIM_BITS-1:0]               frame_height_o,
  output tbcb_pkg::mode_t                   mode_o
);
  import tbcb_pkg::*;

  logic [DIM_BITS-1:0] frame_width_q, frame_width_d;
  logic [DIM_BITS-1:0] frame_height_q, frame_height_d;
  mode_t               mode_q, mode_d;
  logic                wr_en;

  // Writes are always taken; unknown indexes change nothing.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Next register values.
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    mode_d         = mode_q;
    if (wr_en) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:    frame_width_d  = cfg_data_i;
        REG_FRAME_HEIGHT:   frame_height_d = cfg_data_i;
        REG_BAYER_PATTERN:  mode_d.bayer_pattern  = cfg_data_i[1:0];
        REG_PATTERN_ENABLE: mode_d.pattern_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_BITS'(FRAME_WIDTH_RST);
      frame_height_q <= DIM_BITS'(FRAME_HEIGHT_RST);
      mode_q         <= '0;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      mode_q         <= mode_d;
    end
  end

  assign frame_width_o  = frame_width_q;
  assign frame_height_o = frame_height_q;
  assign mode_o         = mode_q;

endmodule

@@ hdl/tbcb_raster.sv @@
// ----------------------------------------------------------------------------
// Bayer color bar test pattern: raster tracking and input stage
// Advances row and column counters per accepted word (bar counters while the
// pattern is on) and registers the pixel with its Bayer channel and bar.
// ----------------------------------------------------------------------------
module tbcb_raster #(
  parameter int unsigned PIXEL_BITS = tbcb_pkg::PIXEL_BITS_DEF,
  parameter int unsigned DIM_BITS   = tbcb_pkg::DIM_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [DIM_BITS-1:0]    frame_width_i,
  input  logic [DIM_BITS-1:0]    frame_height_i,
  input  tbcb_pkg::mode_t        mode_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PIXEL_BITS-1:0]  in_pixel_i,
  output logic                   s1_valid_o,
  input  logic                   s1_ready_i,
  output logic [PIXEL_BITS-1:0]  s1_pixel_o,
  output tbcb_pkg::stage_ctl_t   s1_ctl_o
);
  import tbcb_pkg::*;

  logic [DIM_BITS-1:0]     col_q, col_d, row_q, row_d;
  logic [BLK_CNT_BITS-1:0] blk_q, blk_d;
  logic [2:0]              bar_q, bar_d, bar_upd;
  logic [BLK_CNT_BITS-1:0] blk_upd;
  logic [DIM_BITS+BLK_CNT_BITS-1:0] width_ext;
  logic [BLK_CNT_BITS-1:0] block_width;
  logic [DIM_BITS:0]       col_inc, row_inc;
  logic                    accept;
  logic                    s1_valid_q;
  logic [PIXEL_BITS-1:0]   s1_pixel_q;
  stage_ctl_t              s1_ctl_q, s1_ctl_d;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Block width is an eighth of the frame width, rounded down to even.
  assign width_ext   = {{BLK_CNT_BITS{1'b0}}, frame_width_i} >> 3;
  assign block_width = width_ext[BLK_CNT_BITS-1:0] & BLOCK_MASK;

  // Bar stepping while the generator is on; held otherwise.
  always_comb begin
    blk_upd = blk_q;
    bar_upd = bar_q;
    if (mode_i.pattern_enable) begin
      if (blk_q == block_width) begin
        blk_upd = BLK_CNT_BITS'(1);
        if (bar_q != BAR_YELLOW) begin
          bar_upd = bar_q + 3'd1;
        end
      end else begin
        blk_upd = blk_q + BLK_CNT_BITS'(1);
      end
    end
  end

  // Control for this word uses the bar after stepping.
  always_comb begin
    s1_ctl_d.enable  = mode_i.pattern_enable;
    s1_ctl_d.channel = {row_q[0], col_q[0]} ^ mode_i.bayer_pattern;
    s1_ctl_d.bar     = bar_upd;
  end

  // Raster advance; the end of a row clears the bar state.
  assign col_inc = {1'b0, col_q} + (DIM_BITS+1)'(1);
  assign row_inc = {1'b0, row_q} + (DIM_BITS+1)'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    blk_d = blk_q;
    bar_d = bar_q;
    if (accept) begin
      blk_d = blk_upd;
      bar_d = bar_upd;
      if (col_inc >= {1'b0, frame_width_i}) begin
        col_d = '0;
        blk_d = '0;
        bar_d = BAR_WHITE;
        if (row_inc >= {1'b0, frame_height_i}) begin
          row_d = '0;
        end else begin
          row_d = row_inc[DIM_BITS-1:0];
        end
      end else begin
        col_d = col_inc[DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      blk_q      <= '0;
      bar_q      <= BAR_WHITE;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      blk_q <= blk_d;
      bar_q <= bar_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q <= in_pixel_i;
      s1_ctl_q   <= s1_ctl_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_pixel_o = s1_pixel_q;
  assign s1_ctl_o   = s1_ctl_q;

endmodule

@@ hdl/tbcb_color.sv @@
// ----------------------------------------------------------------------------
// Bayer color bar test pattern: output stage
// Chooses pass-through or bar value and holds it in the result register.
// ----------------------------------------------------------------------------
module tbcb_color #(
  parameter int unsigned PIXEL_BITS = tbcb_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s1_valid_i,
  output logic                  s1_ready_o,
  input  logic [PIXEL_BITS-1:0] s1_pixel_i,
  input  tbcb_pkg::stage_ctl_t  s1_ctl_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] out_pixel_o
);
  import tbcb_pkg::*;

  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] out_pixel_q, out_pixel_d;

  assign s1_ready_o = !out_valid_q || out_ready_i;

  // Bar value is full scale where the bar lights this channel.
  always_comb begin
    if (s1_ctl_i.enable) begin
      out_pixel_d = bar_lit(s1_ctl_i.bar, s1_ctl_i.channel) ? {PIXEL_BITS{1'b1}} : '0;
    end else begin
      out_pixel_d = s1_pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      out_pixel_q <= out_pixel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;

endmodule

@@ hdl/bayer_color_bar_test_pattern.sv @@
// ----------------------------------------------------------------------------
// Bayer color bar test pattern generator
// Raw Bayer pixel stream pass-through or eight-bar color test pattern.
// ----------------------------------------------------------------------------
// Takes one raw pixel word per clock in raster order and gives one pixel word
// per clock while neither side stalls, through an input stage that tracks the
// raster position and bar, and a result register that picks the output value.
// Both stages move whenever the next one can take their word, so a full
// stream runs at one word per cycle and backpressure on the master side stalls
// the slave side only once both stages are full. Frame size, Bayer phase and
// pattern enable are written on the config channel, by the user only while
// the stream is idle; the block does not enforce it. With the pattern on,
// each output is zero or full scale depending on its Bayer channel and on the
// bar (white, black, red, green, blue, cyan, magenta, yellow) its column is in.
module bayer_color_bar_test_pattern #(
  parameter int unsigned PIXEL_BITS = tbcb_pkg::PIXEL_BITS_DEF,
  parameter int unsigned DIM_BITS   = tbcb_pkg::DIM_BITS_DEF,
  localparam int unsigned TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Config channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbcb_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [DIM_BITS-1:0]               cfg_data_i,
  // Slave side.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [TDATA_BITS-1:0]             s_axis_tdata_i,  // pixel_in
  // Master side.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [TDATA_BITS-1:0]             m_axis_tdata_o   // pixel_out
);
  import tbcb_pkg::*;

  logic [DIM_BITS-1:0]   frame_width, frame_height;
  mode_t                 mode;
  logic                  s1_valid, s1_ready;
  logic [PIXEL_BITS-1:0] s1_pixel, out_pixel;
  stage_ctl_t            s1_ctl;

  tbcb_cfg #(
    .DIM_BITS(DIM_BITS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .frame_width_o  (frame_width),
    .frame_height_o (frame_height),
    .mode_o         (mode)
  );

  tbcb_raster #(
    .PIXEL_BITS(PIXEL_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width),
    .frame_height_i (frame_height),
    .mode_i         (mode),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_pixel_i     (s_axis_tdata_i[PIXEL_BITS-1:0]),
    .s1_valid_o     (s1_valid),
    .s1_ready_i     (s1_ready),
    .s1_pixel_o     (s1_pixel),
    .s1_ctl_o       (s1_ctl)
  );

  tbcb_color #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_pixel_i  (s1_pixel),
    .s1_ctl_i    (s1_ctl),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pixel_o (out_pixel)
  );

  assign m_axis_tdata_o = TDATA_BITS'(out_pixel);

  // An empty input stage never holds off the slave side.
  a_in_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> s_axis_tready_o)
    else $error("input stage empty but not ready");

  // A pass-through word reaches the result register unchanged.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_ready && !s1_ctl.enable) |=> (out_pixel == $past(s1_pixel)))
    else $error("pass-through pixel altered");

  // A pattern word is either zero or full scale.
  a_bar_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_ready && s1_ctl.enable) |=>
      ((out_pixel == '0) || (out_pixel == {PIXEL_BITS{1'b1}})))
    else $error("bar value not zero or full scale");

endmodule
